// File: rtl/cceq_pkg.sv
// Shared types, constants and codes for the calendar clock with event queue.
package cceq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int SECS_PER_MIN_DEF  = 60;
  localparam int MINS_PER_HOUR_DEF = 60;
  localparam int HOURS_PER_DAY_DEF = 24;
  localparam int DAYS_PER_MON_DEF  = 50;
  localparam int MONS_PER_YEAR_DEF = 8;

  // Most events released by one advance word.
  localparam int MAX_FIRE = 16;
  localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

  // Calendar divider widths. The reciprocal shift covers every dividend below
  // 2**DIV_DW and every divisor below 2**DIV_SW exactly.
  localparam int DIV_DW = 18;
  localparam int DIV_SW = 8;
  localparam int RCP_SH = DIV_DW + DIV_SW;
  localparam int RCP_W  = RCP_SH + 1;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FIRED = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic MODE_ADD = 1'b0;

  typedef struct packed {
    logic [15:0] tag;
    logic [47:0] tm;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
    logic [RCP_W-1:0]  recip;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic [DIV_SW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_INS_CHK,
    FSM_INS_RD,
    FSM_CAL_GO,
    FSM_CAL_WAIT,
    FSM_FIRE_RD,
    FSM_FIRE_CHK,
    FSM_FIN
  } fsm_t;

endpackage

// File: rtl/calendar_clock_with_event_queue_top.sv
// Top level: calendar clock with a time-ordered event queue.
//
// Input words (in_*): in_tuser selects the request, 0 adds an event with the
// given trigger time and tag, 1 advances the clock by time_units seconds.
// Result words (out_*): every input word produces one or more results; the
// final one of an input carries out_tlast. out_tuser holds the status.
// An add returns one word, added or queue full. An advance rolls the
// calendar over and then releases every queued event due at or before the
// new total, earliest first, up to 16 per advance; with none due, or with a
// zero advance, it returns one word with status "none fired".
// Events sit in a ring buffer in a single-port-read RAM. An add walks from
// the tail toward the head, moving each later entry one slot toward the tail.
// An advance spends 5 constant divisions on the calendar, then releases the
// due events from the head.
// A new word is taken only after the previous one is fully answered.
// Reset clears the queue, the total and sets the date to day 1, month 1,
// year 1. While the receiver stalls, the pending result is held in the
// output register and the block waits.
module calendar_clock_with_event_queue_top #(
  parameter int QUEUE_DEPTH       = cceq_pkg::QUEUE_DEPTH_DEF,
  parameter int SECS_PER_MIN      = cceq_pkg::SECS_PER_MIN_DEF,
  parameter int MINS_PER_HOUR     = cceq_pkg::MINS_PER_HOUR_DEF,
  parameter int HOURS_PER_DAY_P   = cceq_pkg::HOURS_PER_DAY_DEF,
  parameter int DAYS_PER_MONTH    = cceq_pkg::DAYS_PER_MON_DEF,
  parameter int MONTHS_PER_YEAR_P = cceq_pkg::MONS_PER_YEAR_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // time_units, trigger_time, event_tag
  input  logic [0:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // fired_tag, fired_time, cur_second, cur_minute,
                                   // cur_hour, cur_day, cur_month, cur_year, cur_total
  output logic [1:0]   out_tuser,  // status
  output logic         out_tlast
);
  import cceq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  // Rounded-up reciprocals of the calendar divisors.
  localparam longint ONE_SH = longint'(1) << RCP_SH;
  localparam logic [RCP_W-1:0] RCP_SEC =
    RCP_W'((ONE_SH + SECS_PER_MIN - 1) / SECS_PER_MIN);
  localparam logic [RCP_W-1:0] RCP_MIN =
    RCP_W'((ONE_SH + MINS_PER_HOUR - 1) / MINS_PER_HOUR);
  localparam logic [RCP_W-1:0] RCP_HOUR =
    RCP_W'((ONE_SH + HOURS_PER_DAY_P - 1) / HOURS_PER_DAY_P);
  localparam logic [RCP_W-1:0] RCP_DAY =
    RCP_W'((ONE_SH + DAYS_PER_MONTH - 1) / DAYS_PER_MONTH);
  localparam logic [RCP_W-1:0] RCP_MON =
    RCP_W'((ONE_SH + MONTHS_PER_YEAR_P - 1) / MONTHS_PER_YEAR_P);

  fsm_t state_r, state_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     ins_i_r, ins_i_nxt;
  logic [FIRE_W-1:0] nfire_r, nfire_nxt;
  logic [2:0]        cal_idx_r, cal_idx_nxt;
  logic [1:0]        fin_st_r, fin_st_nxt;

  logic [47:0] total_r, total_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [15:0] year_r, year_nxt;

  // Payload registers of the word in flight.
  logic [15:0]       units_r, units_nxt;
  entry_t            new_r, new_nxt;
  entry_t            pend_r, pend_nxt;
  logic [DIV_DW-1:0] carry_r, carry_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [159:0] out_data_r, out_data_nxt;
  logic [1:0]   out_user_r, out_user_nxt;
  logic         out_last_r, out_last_nxt;

  logic      out_free;
  logic      in_acc;
  logic      mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t    mem_wdata, mem_rdata;
  div_req_t  dreq;
  div_rsp_t  drsp;

  logic          emit;
  logic [1:0]    emit_st;
  entry_t        emit_ent;
  logic          emit_last;
  logic [AW-1:0] addr_i, addr_im1;

  // Ring address of head plus an offset below the depth.
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign addr_i   = ring(head_r, ins_i_r);
  assign addr_im1 = ring(head_r, ins_i_r - 1'b1);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == FSM_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  cceq_store #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cceq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    ins_i_nxt   = ins_i_r;
    nfire_nxt   = nfire_r;
    cal_idx_nxt = cal_idx_r;
    fin_st_nxt  = fin_st_r;
    total_nxt   = total_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    day_nxt     = day_r;
    mon_nxt     = mon_r;
    year_nxt    = year_r;
    units_nxt   = units_r;
    new_nxt     = new_r;
    pend_nxt    = pend_r;
    carry_nxt   = carry_r;
    mem_we      = 1'b0;
    mem_waddr   = addr_i;
    mem_wdata   = new_r;
    mem_re      = 1'b0;
    mem_raddr   = addr_im1;
    dreq.start  = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    dreq.recip    = '0;
    emit        = 1'b0;
    emit_st     = fin_st_r;
    emit_ent    = pend_r;
    emit_last   = 1'b1;

    case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          units_nxt  = in_tdata[15:0];
          new_nxt.tm = in_tdata[63:16];
          new_nxt.tag = in_tdata[79:64];
          pend_nxt   = '0;
          nfire_nxt  = '0;
          ins_i_nxt  = count_r;
          cal_idx_nxt = '0;
          carry_nxt  = '0;
          if (in_tuser[0] == MODE_ADD) begin
            if (count_r >= CW'(QUEUE_DEPTH)) begin
              fin_st_nxt = ST_FULL;
              state_nxt  = FSM_FIN;
            end else begin
              fin_st_nxt = ST_ADDED;
              state_nxt  = FSM_INS_CHK;
            end
          end else begin
            fin_st_nxt = ST_NONE;
            if (in_tdata[15:0] == 16'd0) begin
              state_nxt = FSM_FIN;
            end else begin
              total_nxt = total_r + 48'(in_tdata[15:0]);
              state_nxt = FSM_CAL_GO;
            end
          end
        end
      end
      FSM_INS_CHK: begin
        if (ins_i_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = FSM_FIN;
        end else begin
          mem_re    = 1'b1;
          state_nxt = FSM_INS_RD;
        end
      end
      FSM_INS_RD: begin
        mem_we = 1'b1;
        // A later trigger time moves one slot toward the tail; equal times stay.
        if (mem_rdata.tm > new_r.tm) begin
          mem_wdata = mem_rdata;
          ins_i_nxt = ins_i_r - 1'b1;
          state_nxt = FSM_INS_CHK;
        end else begin
          count_nxt = count_r + 1'b1;
          state_nxt = FSM_FIN;
        end
      end
      FSM_CAL_GO: begin
        dreq.start = 1'b1;
        case (cal_idx_r)
          3'd0: begin
            dreq.dividend = DIV_DW'(sec_r) + DIV_DW'(units_r);
            dreq.divisor  = DIV_SW'(SECS_PER_MIN);
            dreq.recip    = RCP_SEC;
          end
          3'd1: begin
            dreq.dividend = DIV_DW'(min_r) + carry_r;
            dreq.divisor  = DIV_SW'(MINS_PER_HOUR);
            dreq.recip    = RCP_MIN;
          end
          3'd2: begin
            dreq.dividend = DIV_DW'(hour_r) + carry_r;
            dreq.divisor  = DIV_SW'(HOURS_PER_DAY_P);
            dreq.recip    = RCP_HOUR;
          end
          3'd3: begin
            dreq.dividend = DIV_DW'(day_r - 1'b1) + carry_r;
            dreq.divisor  = DIV_SW'(DAYS_PER_MONTH);
            dreq.recip    = RCP_DAY;
          end
          default: begin
            dreq.dividend = DIV_DW'(mon_r - 1'b1) + carry_r;
            dreq.divisor  = DIV_SW'(MONTHS_PER_YEAR_P);
            dreq.recip    = RCP_MON;
          end
        endcase
        state_nxt = FSM_CAL_WAIT;
      end
      FSM_CAL_WAIT: begin
        if (drsp.done) begin
          carry_nxt   = drsp.quot;
          cal_idx_nxt = cal_idx_r + 1'b1;
          state_nxt   = FSM_CAL_GO;
          case (cal_idx_r)
            3'd0: sec_nxt  = drsp.rem[5:0];
            3'd1: min_nxt  = drsp.rem[5:0];
            3'd2: hour_nxt = drsp.rem[4:0];
            3'd3: day_nxt  = 6'(drsp.rem + 1'b1);
            default: begin
              mon_nxt   = 4'(drsp.rem + 1'b1);
              year_nxt  = year_r + drsp.quot[15:0];
              state_nxt = FSM_FIRE_RD;
            end
          endcase
        end
      end
      FSM_FIRE_RD: begin
        if (count_r == '0 || nfire_r == FIRE_W'(MAX_FIRE)) begin
          state_nxt = FSM_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_r;
          state_nxt = FSM_FIRE_CHK;
        end
      end
      FSM_FIRE_CHK: begin
        if (mem_rdata.tm > total_r) begin
          state_nxt = FSM_FIN;
        end else if (nfire_r == '0 || out_free) begin
          // The previous due event goes out now that another one follows it.
          emit       = (nfire_r != '0);
          emit_st    = ST_FIRED;
          emit_last  = 1'b0;
          pend_nxt   = mem_rdata;
          fin_st_nxt = ST_FIRED;
          nfire_nxt  = nfire_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          head_nxt   = ring(head_r, CW'(1));
          state_nxt  = FSM_FIRE_RD;
        end
      end
      FSM_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = emit_st;
      out_last_nxt  = emit_last;
      out_data_nxt  = {5'd0, total_r, year_r, mon_r, day_r, hour_r, min_r, sec_r,
                       emit_ent.tm, emit_ent.tag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      ins_i_r     <= '0;
      nfire_r     <= '0;
      cal_idx_r   <= '0;
      fin_st_r    <= ST_NONE;
      total_r     <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      day_r       <= 6'd1;
      mon_r       <= 4'd1;
      year_r      <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      ins_i_r     <= ins_i_nxt;
      nfire_r     <= nfire_nxt;
      cal_idx_r   <= cal_idx_nxt;
      fin_st_r    <= fin_st_nxt;
      total_r     <= total_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      mon_r       <= mon_nxt;
      year_r      <= year_nxt;
      out_valid_r <= out_valid_nxt;
    end
    units_r    <= units_nxt;
    new_r      <= new_nxt;
    pend_r     <= pend_nxt;
    carry_r    <= carry_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("event count above queue depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_st == ST_FULL) |-> count_r == CW'(QUEUE_DEPTH))
    else $error("queue full reported with room left");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfire_r <= FIRE_W'(MAX_FIRE)) else $error("too many events released");

  a_no_emit_over_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free) else $error("result overwrote a waiting word");
`endif

endmodule

// File: rtl/cceq_div.sv
// Two-stage reciprocal-multiply divider by a constant, used for the calendar rollover.
module cceq_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cceq_pkg::div_req_t req,
  output cceq_pkg::div_rsp_t rsp
);
  import cceq_pkg::*;

  localparam int PW = DIV_DW + RCP_W;
  localparam int BW = DIV_DW + DIV_SW;

  logic              ph1_r, ph1_nxt;
  logic              ph2_r, ph2_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW-1:0] dvd_r, dvd_nxt;
  logic [DIV_SW-1:0] dsr_r, dsr_nxt;
  logic [RCP_W-1:0]  rcp_r, rcp_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_SW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] quo_c;
  logic [BW-1:0]     back_c;

  always_comb begin
    ph1_nxt  = 1'b0;
    ph2_nxt  = 1'b0;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rcp_nxt  = rcp_r;
    prod_nxt = prod_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    quo_c    = prod_r[RCP_SH +: DIV_DW];
    back_c   = BW'(quo_c) * BW'(dsr_r);
    if (req.start) begin
      ph1_nxt = 1'b1;
      dvd_nxt = req.dividend;
      dsr_nxt = req.divisor;
      rcp_nxt = req.recip;
    end else if (ph1_r) begin
      prod_nxt = PW'(dvd_r) * PW'(rcp_r);
      ph2_nxt  = 1'b1;
    end else if (ph2_r) begin
      quo_nxt  = quo_c;
      rem_nxt  = DIV_SW'(BW'(dvd_r) - back_c);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r  <= 1'b0;
      ph2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph1_r  <= ph1_nxt;
      ph2_r  <= ph2_nxt;
      done_r <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rcp_r  <= rcp_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/cceq_store.sv
// Event store: one write port and one registered read port.
module cceq_store #(
  parameter int DEPTH = cceq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cceq_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output cceq_pkg::entry_t rdata
);
  import cceq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
